// ----- sv/mit_command_frame_encoder_macros.svh -----
// ============================================================================
// Command frame encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ============================================================================
`ifndef MIT_COMMAND_FRAME_ENCODER_MACROS_SVH
`define MIT_COMMAND_FRAME_ENCODER_MACROS_SVH

// Condition must hold at every edge outside reset
`define MCFE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next
`define MCFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mcfe_pkg.sv -----
// ============================================================================
// mcfe_pkg
// Widths, command kinds, register indexes and frame codes of the encoder.
// ============================================================================
`timescale 1ns / 1ps

package mcfe_pkg;

    localparam int MOTORS         = 10;
    localparam int MOTORS_PER_BUS = 5;

    localparam int Q_W    = 32;   // Q16.16 value
    localparam int LIM_W  = 31;   // unsigned bounds
    localparam int MASK_W = 10;   // wide torque mask
    localparam int IDX_W  = 4;
    localparam int NODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 32;

    localparam int POS_BITS   = 16;
    localparam int OTHER_BITS = 12;

    localparam logic [BYTE_W-1:0] REPEAT_BYTE  = 8'hFF;
    localparam logic [BYTE_W-1:0] CODE_ENABLE  = 8'hFC;
    localparam logic [BYTE_W-1:0] CODE_DISABLE = 8'hFD;
    localparam logic [BYTE_W-1:0] CODE_ZERO    = 8'hFE;

    typedef enum logic [1:0] {
        KIND_IMPEDANCE = 2'd0,
        KIND_ENABLE    = 2'd1,
        KIND_DISABLE   = 2'd2,
        KIND_ZERO      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_POSITION_LIMIT    = 3'd0,
        REG_VELOCITY_LIMIT    = 3'd1,
        REG_STIFFNESS_MAX     = 3'd2,
        REG_DAMPING_MAX       = 3'd3,
        REG_TORQUE_MIN        = 3'd4,
        REG_TORQUE_MAX_NARROW = 3'd5,
        REG_TORQUE_MAX_WIDE   = 3'd6,
        REG_WIDE_TORQUE_MASK  = 3'd7
    } cfg_index_t;

endpackage

// ----- sv/mcfe_if.sv -----
// ============================================================================
// mcfe channel interfaces
// Valid/ready channels for commands, frames and register writes.
// ============================================================================
`timescale 1ns / 1ps

interface mcfe_cmd_if;
    import mcfe_pkg::*;

    logic                    valid;
    logic                    ready;
    kind_t                   kind;
    logic [IDX_W-1:0]        motor_index;
    logic                    direction_normal;
    logic signed [Q_W-1:0]   position_target;
    logic signed [Q_W-1:0]   velocity_target;
    logic signed [Q_W-1:0]   torque_target;
    logic signed [Q_W-1:0]   stiffness;
    logic signed [Q_W-1:0]   damping;

    modport source (
        output valid, kind, motor_index, direction_normal, position_target,
               velocity_target, torque_target, stiffness, damping,
        input  ready
    );
    modport sink (
        input  valid, kind, motor_index, direction_normal, position_target,
               velocity_target, torque_target, stiffness, damping,
        output ready
    );
endinterface

interface mcfe_frame_if;
    import mcfe_pkg::*;

    logic              valid;
    logic              ready;
    logic              bus_select;
    logic [NODE_W-1:0] node_id;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [BYTE_W-1:0] byte3;
    logic [BYTE_W-1:0] byte4;
    logic [BYTE_W-1:0] byte5;
    logic [BYTE_W-1:0] byte6;
    logic [BYTE_W-1:0] byte7;

    modport source (
        output valid, bus_select, node_id, byte0, byte1, byte2, byte3,
               byte4, byte5, byte6, byte7,
        input  ready
    );
    modport sink (
        input  valid, bus_select, node_id, byte0, byte1, byte2, byte3,
               byte4, byte5, byte6, byte7,
        output ready
    );
endinterface

interface mcfe_cfg_if;
    import mcfe_pkg::*;

    logic             valid;
    logic             ready;
    cfg_index_t       index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/mit_command_frame_encoder.sv -----
// ============================================================================
// mit_command_frame_encoder
// Packs motor commands into 8-byte bus frames, with routing to bus and node.
// ============================================================================
//
//  channel | dir | beat
//  --------+-----+---------------------------------------------------------
//  cmd     | in  | kind, motor index, direction, five Q16.16 targets/gains
//  frame   | out | bus select, node id, frame bytes 0..7
//  cfg     | in  | register index and 32-bit write data, always ready
//
//  One beat enters per clock unless a stall backs up to the command side;
//  the 16-stage restoring divider yields one quotient bit per stage.
//  Every stage has its own valid bit and loads when it is empty or its
//  successor moves, so bubbles close up and a stall backs up stage by stage.
//  Reset clears the valid bits and loads the register defaults; no clearing
//  pass is needed.
// ============================================================================
`timescale 1ns / 1ps
`include "mit_command_frame_encoder_macros.svh"

module mit_command_frame_encoder (
    input  logic         clk,
    input  logic         rst_n,
    mcfe_cfg_if.sink     cfg,
    mcfe_cmd_if.sink     cmd,
    mcfe_frame_if.source frame
);
    import mcfe_pkg::*;

    // ------------------------------------------------------------------------
    // Local constants
    // ------------------------------------------------------------------------
    localparam int LANES     = 5;
    localparam int LANE_POS  = 0;
    localparam int LANE_VEL  = 1;
    localparam int LANE_KP   = 2;
    localparam int LANE_KD   = 3;
    localparam int LANE_TQ   = 4;
    localparam int LANE_BITS [LANES] = '{POS_BITS, OTHER_BITS, OTHER_BITS,
                                         OTHER_BITS, OTHER_BITS};

    localparam int X_W       = Q_W + 1;          // room for negated minimum
    localparam int ACC_W     = Q_W + POS_BITS;   // remainder plus quotient
    localparam int DIV_STEPS = POS_BITS;
    localparam int NSTAGE    = DIV_STEPS + 4;    // prep, clamp, div init+steps, out
    localparam int ST_DIV0   = 2;
    localparam int ST_OUT    = NSTAGE - 1;
    localparam int IDX_SPAN  = 2 ** IDX_W;

    localparam logic [LIM_W-1:0]      POSITION_LIMIT_RST    = 31'd819200;
    localparam logic [LIM_W-1:0]      VELOCITY_LIMIT_RST    = 31'd2503475;
    localparam logic [LIM_W-1:0]      STIFFNESS_MAX_RST     = 31'd32768000;
    localparam logic [LIM_W-1:0]      DAMPING_MAX_RST       = 31'd327680;
    localparam logic signed [Q_W-1:0] TORQUE_MIN_RST        = -32'sd786432;
    localparam logic [LIM_W-1:0]      TORQUE_MAX_NARROW_RST = 31'd786432;
    localparam logic [LIM_W-1:0]      TORQUE_MAX_WIDE_RST   = 31'd1310720;
    localparam logic [MASK_W-1:0]     WIDE_TORQUE_MASK_RST  = 10'd462;

    // ------------------------------------------------------------------------
    // Stage payload types
    // ------------------------------------------------------------------------
    typedef logic signed [X_W-1:0] sval_t;

    typedef struct packed {
        kind_t             kind;
        logic              bus;
        logic [NODE_W-1:0] node;
    } route_t;

    // after sign handling and bound selection
    typedef struct packed {
        route_t              rt;
        sval_t [LANES-1:0]   x;
        sval_t [LANES-1:0]   lo;
        sval_t [LANES-1:0]   hi;
    } prep_t;

    // offset into the range and the range width, both non-negative
    typedef struct packed {
        route_t                     rt;
        logic [LANES-1:0][Q_W-1:0]  d;
        logic [LANES-1:0][Q_W-1:0]  span;
    } clamp_t;

    // divider lane: upper part remainder, lower part numerator/quotient bits
    typedef struct packed {
        route_t                      rt;
        logic [LANES-1:0][Q_W-1:0]   span;
        logic [LANES-1:0][ACC_W-1:0] acc;
    } div_t;

    typedef struct packed {
        logic                          bus;
        logic [NODE_W-1:0]             node;
        logic [7:0][BYTE_W-1:0]        b;
    } frame_t;

    // One restoring step: shift in the next numerator bit, subtract if it fits.
    function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                   input logic [Q_W-1:0]   span);
        logic [Q_W:0]   trial;
        logic [Q_W:0]   diff;
        logic           ge;
        logic [Q_W-1:0] rem;
        trial = acc[ACC_W-1 -: Q_W+1];
        diff  = trial - {1'b0, span};
        ge    = !diff[Q_W];
        rem   = ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
        return {rem, acc[ACC_W-Q_W-2:0], ge};
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [LIM_W-1:0]      position_limit_reg;
    logic [LIM_W-1:0]      velocity_limit_reg;
    logic [LIM_W-1:0]      stiffness_max_reg;
    logic [LIM_W-1:0]      damping_max_reg;
    logic signed [Q_W-1:0] torque_min_reg;
    logic [LIM_W-1:0]      torque_max_narrow_reg;
    logic [LIM_W-1:0]      torque_max_wide_reg;
    logic [MASK_W-1:0]     wide_torque_mask_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_limit_reg    <= POSITION_LIMIT_RST;
            velocity_limit_reg    <= VELOCITY_LIMIT_RST;
            stiffness_max_reg     <= STIFFNESS_MAX_RST;
            damping_max_reg       <= DAMPING_MAX_RST;
            torque_min_reg        <= TORQUE_MIN_RST;
            torque_max_narrow_reg <= TORQUE_MAX_NARROW_RST;
            torque_max_wide_reg   <= TORQUE_MAX_WIDE_RST;
            wide_torque_mask_reg  <= WIDE_TORQUE_MASK_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_POSITION_LIMIT:    position_limit_reg    <= cfg.data[LIM_W-1:0];
                REG_VELOCITY_LIMIT:    velocity_limit_reg    <= cfg.data[LIM_W-1:0];
                REG_STIFFNESS_MAX:     stiffness_max_reg     <= cfg.data[LIM_W-1:0];
                REG_DAMPING_MAX:       damping_max_reg       <= cfg.data[LIM_W-1:0];
                REG_TORQUE_MIN:        torque_min_reg        <= $signed(cfg.data[Q_W-1:0]);
                REG_TORQUE_MAX_NARROW: torque_max_narrow_reg <= cfg.data[LIM_W-1:0];
                REG_TORQUE_MAX_WIDE:   torque_max_wide_reg   <= cfg.data[LIM_W-1:0];
                REG_WIDE_TORQUE_MASK:  wide_torque_mask_reg  <= cfg.data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control: a stage moves when empty or its successor moves
    // ------------------------------------------------------------------------
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] adv;
    logic [NSTAGE-1:0] valid_in;
    logic [NSTAGE-1:0] stalled_vec;

    always_comb
    begin
        adv[ST_OUT] = !valid_reg[ST_OUT] || frame.ready;
        for (int k = ST_OUT - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign valid_in    = {valid_reg[NSTAGE-2:0], cmd.valid};
    assign valid_next  = (adv & valid_in) | (~adv & valid_reg);
    assign stalled_vec = valid_reg & ~adv;
    assign cmd.ready   = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: routing, direction, bound selection
    // ------------------------------------------------------------------------
    prep_t                prep_reg;
    prep_t                prep_next;
    logic [IDX_SPAN-1:0]  mask_ext;
    logic [IDX_W:0]       node_sum;
    logic                 wide_sel;

    assign mask_ext = IDX_SPAN'(wide_torque_mask_reg);

    always_comb
    begin
        prep_next.rt.kind = cmd.kind;
        prep_next.rt.bus  = ({1'b0, cmd.motor_index} >= (IDX_W+1)'(MOTORS_PER_BUS));
        node_sum          = {1'b0, cmd.motor_index} + (IDX_W+1)'(1)
                          - (prep_next.rt.bus ? (IDX_W+1)'(MOTORS_PER_BUS) : '0);
        prep_next.rt.node = node_sum[NODE_W-1:0];

        // indices past the motor count fall back to the narrow bound
        wide_sel = ({1'b0, cmd.motor_index} < (IDX_W+1)'(MOTORS))
                && mask_ext[cmd.motor_index];

        prep_next.x[LANE_POS]  = cmd.direction_normal ? X_W'(cmd.position_target)
                                                      : -X_W'(cmd.position_target);
        prep_next.x[LANE_VEL]  = cmd.direction_normal ? X_W'(cmd.velocity_target)
                                                      : -X_W'(cmd.velocity_target);
        prep_next.x[LANE_TQ]   = cmd.direction_normal ? X_W'(cmd.torque_target)
                                                      : -X_W'(cmd.torque_target);
        prep_next.x[LANE_KP]   = X_W'(cmd.stiffness);
        prep_next.x[LANE_KD]   = X_W'(cmd.damping);

        prep_next.lo[LANE_POS] = -X_W'(position_limit_reg);
        prep_next.hi[LANE_POS] = X_W'(position_limit_reg);
        prep_next.lo[LANE_VEL] = -X_W'(velocity_limit_reg);
        prep_next.hi[LANE_VEL] = X_W'(velocity_limit_reg);
        prep_next.lo[LANE_KP]  = '0;
        prep_next.hi[LANE_KP]  = X_W'(stiffness_max_reg);
        prep_next.lo[LANE_KD]  = '0;
        prep_next.hi[LANE_KD]  = X_W'(damping_max_reg);
        prep_next.lo[LANE_TQ]  = X_W'(torque_min_reg);
        prep_next.hi[LANE_TQ]  = X_W'(wide_sel ? torque_max_wide_reg
                                               : torque_max_narrow_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prep_reg <= prep_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: clamp and offset; an empty range becomes 0 / 1 so its code is 0
    // ------------------------------------------------------------------------
    clamp_t clamp_reg;
    clamp_t clamp_next;

    always_comb
    begin
        sval_t span_s;
        sval_t xc;
        clamp_next.rt = prep_reg.rt;
        for (int i = 0; i < LANES; i++)
        begin
            span_s = $signed(prep_reg.hi[i]) - $signed(prep_reg.lo[i]);
            if ($signed(prep_reg.x[i]) < $signed(prep_reg.lo[i]))
            begin
                xc = prep_reg.lo[i];
            end
            else if ($signed(prep_reg.x[i]) > $signed(prep_reg.hi[i]))
            begin
                xc = prep_reg.hi[i];
            end
            else
            begin
                xc = prep_reg.x[i];
            end
            if (span_s <= 0)
            begin
                clamp_next.d[i]    = '0;
                clamp_next.span[i] = Q_W'(1);
            end
            else
            begin
                clamp_next.d[i]    = Q_W'(xc - $signed(prep_reg.lo[i]));
                clamp_next.span[i] = Q_W'(span_s);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            clamp_reg <= clamp_next;
        end
    end

    // ------------------------------------------------------------------------
    // Divider: init stage forms d * (2^bits - 1), then one quotient bit a stage
    // ------------------------------------------------------------------------
    div_t div_reg  [DIV_STEPS+1];
    div_t div_next [DIV_STEPS+1];

    always_comb
    begin
        div_next[0].rt   = clamp_reg.rt;
        div_next[0].span = clamp_reg.span;
        for (int i = 0; i < LANES; i++)
        begin
            div_next[0].acc[i] = (ACC_W'(clamp_reg.d[i]) << LANE_BITS[i])
                               - ACC_W'(clamp_reg.d[i]);
        end
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            div_next[k].rt   = div_reg[k-1].rt;
            div_next[k].span = div_reg[k-1].span;
            for (int i = 0; i < LANES; i++)
            begin
                div_next[k].acc[i] = div_step(div_reg[k-1].acc[i],
                                              div_reg[k-1].span[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_STEPS; k++)
        begin
            if (adv[ST_DIV0+k])
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stage: big-endian packing or control frame
    // ------------------------------------------------------------------------
    frame_t out_reg;
    frame_t out_next;

    always_comb
    begin
        logic [POS_BITS-1:0]   pos_c;
        logic [OTHER_BITS-1:0] vel_c;
        logic [OTHER_BITS-1:0] kp_c;
        logic [OTHER_BITS-1:0] kd_c;
        logic [OTHER_BITS-1:0] tq_c;
        pos_c = div_reg[DIV_STEPS].acc[LANE_POS][POS_BITS-1:0];
        vel_c = div_reg[DIV_STEPS].acc[LANE_VEL][OTHER_BITS-1:0];
        kp_c  = div_reg[DIV_STEPS].acc[LANE_KP][OTHER_BITS-1:0];
        kd_c  = div_reg[DIV_STEPS].acc[LANE_KD][OTHER_BITS-1:0];
        tq_c  = div_reg[DIV_STEPS].acc[LANE_TQ][OTHER_BITS-1:0];

        out_next.bus  = div_reg[DIV_STEPS].rt.bus;
        out_next.node = div_reg[DIV_STEPS].rt.node;
        out_next.b    = {8{REPEAT_BYTE}};
        case (div_reg[DIV_STEPS].rt.kind)
            KIND_IMPEDANCE:
            begin
                out_next.b[0] = pos_c[15:8];
                out_next.b[1] = pos_c[7:0];
                out_next.b[2] = vel_c[11:4];
                out_next.b[3] = {vel_c[3:0], kp_c[11:8]};
                out_next.b[4] = kp_c[7:0];
                out_next.b[5] = kd_c[11:4];
                out_next.b[6] = {kd_c[3:0], tq_c[11:8]};
                out_next.b[7] = tq_c[7:0];
            end
            KIND_ENABLE:  out_next.b[7] = CODE_ENABLE;
            KIND_DISABLE: out_next.b[7] = CODE_DISABLE;
            KIND_ZERO:    out_next.b[7] = CODE_ZERO;
            default:      out_next.b[7] = CODE_ZERO;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign frame.valid      = valid_reg[ST_OUT];
    assign frame.bus_select = out_reg.bus;
    assign frame.node_id    = out_reg.node;
    assign frame.byte0      = out_reg.b[0];
    assign frame.byte1      = out_reg.b[1];
    assign frame.byte2      = out_reg.b[2];
    assign frame.byte3      = out_reg.b[3];
    assign frame.byte4      = out_reg.b[4];
    assign frame.byte5      = out_reg.b[5];
    assign frame.byte6      = out_reg.b[6];
    assign frame.byte7      = out_reg.b[7];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    logic div_rem_ok;
    logic narrow_code_ok;

    // every live divider beat keeps its partial remainder below the span
    always_comb
    begin
        div_rem_ok = 1'b1;
        for (int k = 0; k <= DIV_STEPS; k++)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                div_rem_ok = div_rem_ok && (!valid_reg[ST_DIV0+k]
                    || (div_reg[k].acc[i][ACC_W-1 -: Q_W] < div_reg[k].span[i]));
            end
        end
    end

    // 12-bit lanes must finish with a quotient that fits 12 bits
    always_comb
    begin
        narrow_code_ok = 1'b1;
        for (int i = LANE_VEL; i < LANES; i++)
        begin
            narrow_code_ok = narrow_code_ok && (!valid_reg[ST_OUT-1]
                || (div_reg[DIV_STEPS].acc[i][POS_BITS-1:OTHER_BITS] == '0));
        end
    end

    `MCFE_ASSERT_ALWAYS(a_div_rem_below_span, div_rem_ok, "divider remainder reached span")
    `MCFE_ASSERT_ALWAYS(a_narrow_code_fits, narrow_code_ok, "12-bit code overflowed")
    `MCFE_ASSERT_NEXT(a_stalled_beat_kept, |stalled_vec, (valid_reg & $past(stalled_vec)) == $past(stalled_vec), "stalled beat dropped")

endmodule

// ----- verif/frame_encode_checker.sv -----
// ============================================================================
// frame_encode_checker
// Watches the command, frame and register channels. Predicts each frame from
// its command beat and a shadow copy of the registers, then compares frames
// in order.
// ============================================================================
`timescale 1ns / 1ps

module frame_encode_checker (
    input  logic   clk,
    input  logic   rst_n,
    mcfe_cfg_if    cfg_mon,
    mcfe_cmd_if    cmd_mon,
    mcfe_frame_if  frame_mon,
    output int     mismatches,
    output int     frames_owed
);
    import mcfe_pkg::*;

    // register defaults after reset
    localparam logic [LIM_W-1:0]  POS_LIM_RST    = 31'd819200;
    localparam logic [LIM_W-1:0]  VEL_LIM_RST    = 31'd2503475;
    localparam logic [LIM_W-1:0]  STIFF_MAX_RST  = 31'd32768000;
    localparam logic [LIM_W-1:0]  DAMP_MAX_RST   = 31'd327680;
    localparam logic [Q_W-1:0]    TORQUE_LO_RST  = 32'hFFF4_0000;
    localparam logic [LIM_W-1:0]  NARROW_MAX_RST = 31'd786432;
    localparam logic [LIM_W-1:0]  WIDE_MAX_RST   = 31'd1310720;
    localparam logic [MASK_W-1:0] WIDE_MASK_RST  = 10'd462;

    typedef struct packed {
        logic                          bus;
        logic [NODE_W-1:0]             node;
        logic [7:0][BYTE_W-1:0]        data;   // data[0] is byte0
    } frame_beat_t;

    logic [LIM_W-1:0]      pos_lim;
    logic [LIM_W-1:0]      vel_lim;
    logic [LIM_W-1:0]      stiff_max;
    logic [LIM_W-1:0]      damp_max;
    logic signed [Q_W-1:0] torque_lo;
    logic [LIM_W-1:0]      narrow_max;
    logic [LIM_W-1:0]      wide_max;
    logic [MASK_W-1:0]     wide_mask;

    frame_beat_t expected_frames[$];
    frame_beat_t want;
    frame_beat_t got;

    // clamp then floor((x - lo) * (2^bits - 1) / span); empty or inverted range gives 0
    function automatic longint quantize_code(longint x, longint lo, longint hi, int bits);
        longint span;
        longint full_scale;
        span       = hi - lo;
        full_scale = (longint'(1) << bits) - 1;
        if (span <= 0)
            return 0;
        if (x < lo)
            x = lo;
        if (x > hi)
            x = hi;
        return ((x - lo) * full_scale) / span;
    endfunction

    function automatic frame_beat_t pack_frame(
        kind_t k, logic [IDX_W-1:0] idx, logic dir_normal,
        logic signed [Q_W-1:0] p, logic signed [Q_W-1:0] v, logic signed [Q_W-1:0] t,
        logic signed [Q_W-1:0] kp, logic signed [Q_W-1:0] kd);
        frame_beat_t           f;
        logic [IDX_W-1:0]      node_full;
        longint                q, qd, tq, tmax;
        logic [POS_BITS-1:0]   p_code;
        logic [OTHER_BITS-1:0] v_code, kp_code, kd_code, t_code;

        f.bus     = (idx >= MOTORS_PER_BUS);
        node_full = f.bus ? IDX_W'(idx + 1 - MOTORS_PER_BUS) : IDX_W'(idx + 1);
        f.node    = node_full[NODE_W-1:0];

        if (k == KIND_IMPEDANCE) begin
            q  = longint'(p);
            qd = longint'(v);
            tq = longint'(t);
            // inverted mounting: exact at 64 bits, so the most negative value survives
            if (!dir_normal) begin
                q  = -q;
                qd = -qd;
                tq = -tq;
            end
            tmax = longint'(narrow_max);
            if (idx < MOTORS && wide_mask[idx])
                tmax = longint'(wide_max);

            p_code  = POS_BITS'(quantize_code(q, -longint'(pos_lim), longint'(pos_lim),
                                              POS_BITS));
            v_code  = OTHER_BITS'(quantize_code(qd, -longint'(vel_lim), longint'(vel_lim),
                                                OTHER_BITS));
            kp_code = OTHER_BITS'(quantize_code(longint'(kp), 0, longint'(stiff_max),
                                                OTHER_BITS));
            kd_code = OTHER_BITS'(quantize_code(longint'(kd), 0, longint'(damp_max),
                                                OTHER_BITS));
            t_code  = OTHER_BITS'(quantize_code(tq, longint'(torque_lo), tmax, OTHER_BITS));

            f.data[0] = p_code[15:8];
            f.data[1] = p_code[7:0];
            f.data[2] = v_code[11:4];
            f.data[3] = {v_code[3:0], kp_code[11:8]};
            f.data[4] = kp_code[7:0];
            f.data[5] = kd_code[11:4];
            f.data[6] = {kd_code[3:0], t_code[11:8]};
            f.data[7] = t_code[7:0];
        end else begin
            for (int i = 0; i < 7; i++)
                f.data[i] = REPEAT_BYTE;
            case (k)
                KIND_ENABLE:  f.data[7] = CODE_ENABLE;
                KIND_DISABLE: f.data[7] = CODE_DISABLE;
                default:      f.data[7] = CODE_ZERO;
            endcase
        end
        return f;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_lim    = POS_LIM_RST;
            vel_lim    = VEL_LIM_RST;
            stiff_max  = STIFF_MAX_RST;
            damp_max   = DAMP_MAX_RST;
            torque_lo  = TORQUE_LO_RST;
            narrow_max = NARROW_MAX_RST;
            wide_max   = WIDE_MAX_RST;
            wide_mask  = WIDE_MASK_RST;
            expected_frames.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.index)
                    REG_POSITION_LIMIT:    pos_lim    = cfg_mon.data[LIM_W-1:0];
                    REG_VELOCITY_LIMIT:    vel_lim    = cfg_mon.data[LIM_W-1:0];
                    REG_STIFFNESS_MAX:     stiff_max  = cfg_mon.data[LIM_W-1:0];
                    REG_DAMPING_MAX:       damp_max   = cfg_mon.data[LIM_W-1:0];
                    REG_TORQUE_MIN:        torque_lo  = cfg_mon.data;
                    REG_TORQUE_MAX_NARROW: narrow_max = cfg_mon.data[LIM_W-1:0];
                    REG_TORQUE_MAX_WIDE:   wide_max   = cfg_mon.data[LIM_W-1:0];
                    REG_WIDE_TORQUE_MASK:  wide_mask  = cfg_mon.data[MASK_W-1:0];
                    default: ;
                endcase
            end

            if (cmd_mon.valid && cmd_mon.ready)
                expected_frames.push_back(pack_frame(
                    cmd_mon.kind, cmd_mon.motor_index, cmd_mon.direction_normal,
                    cmd_mon.position_target, cmd_mon.velocity_target, cmd_mon.torque_target,
                    cmd_mon.stiffness, cmd_mon.damping));

            if (frame_mon.valid && frame_mon.ready) begin
                got.bus     = frame_mon.bus_select;
                got.node    = frame_mon.node_id;
                got.data[0] = frame_mon.byte0;
                got.data[1] = frame_mon.byte1;
                got.data[2] = frame_mon.byte2;
                got.data[3] = frame_mon.byte3;
                got.data[4] = frame_mon.byte4;
                got.data[5] = frame_mon.byte5;
                got.data[6] = frame_mon.byte6;
                got.data[7] = frame_mon.byte7;
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected frame beat, expected none, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_frames.pop_front();
                    if (got.bus !== want.bus) begin
                        $display("%0t: bus_select expected %0d, got %0d",
                                 $time, want.bus, got.bus);
                        mismatches++;
                    end
                    if (got.node !== want.node) begin
                        $display("%0t: node_id expected %0d, got %0d",
                                 $time, want.node, got.node);
                        mismatches++;
                    end
                    for (int i = 0; i < 8; i++)
                        if (got.data[i] !== want.data[i]) begin
                            $display("%0t: byte%0d expected %h, got %h",
                                     $time, i, want.data[i], got.data[i]);
                            mismatches++;
                        end
                end
            end

            frames_owed = expected_frames.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// ============================================================================
// tb_top
// Drives the command frame encoder with directed and random command beats
// over a series of register settings, with random idling on both channels.
// The checker beside the encoder predicts and compares every frame.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import mcfe_pkg::*;

    localparam int RESET_CYCLES    = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int LONG_HOLD       = 150;   // frame side held off; pipeline is ~20 deep
    localparam int HOLD_AT_ITEM    = 40;
    localparam int DRAIN_CYCLES    = 40;    // leave room for a stray frame
    localparam int WATCHDOG_LIMIT  = 3000;  // cycles without any beat on any channel

    typedef struct {
        kind_t                 kind;
        logic [IDX_W-1:0]      idx;
        logic                  dir_normal;
        logic signed [Q_W-1:0] p;
        logic signed [Q_W-1:0] v;
        logic signed [Q_W-1:0] t;
        logic signed [Q_W-1:0] kp;
        logic signed [Q_W-1:0] kd;
    } cmd_beat_t;

    typedef logic [CFG_W-1:0] reg_set_t [8];

    logic clk;
    logic rst_n;

    mcfe_cmd_if   cmd_bus ();
    mcfe_frame_if frame_bus ();
    mcfe_cfg_if   cfg_bus ();

    int  mismatches;
    int  frames_owed;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_token;      // flipped to ask the receiver for one long hold-off

    // clamp edges of the current setting, fed into the random values
    logic signed [Q_W-1:0] boundary_vals[$];

    mit_command_frame_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .cmd   (cmd_bus),
        .frame (frame_bus)
    );

    frame_encode_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_mon     (cfg_bus),
        .cmd_mon     (cmd_bus),
        .frame_mon   (frame_bus),
        .mismatches  (mismatches),
        .frames_owed (frames_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic cmd_beat_t make_cmd(
        kind_t k, int idx, int dir_normal,
        logic signed [Q_W-1:0] p, logic signed [Q_W-1:0] v, logic signed [Q_W-1:0] t,
        logic signed [Q_W-1:0] kp, logic signed [Q_W-1:0] kd);
        cmd_beat_t c;
        c.kind       = k;
        c.idx        = IDX_W'(idx);
        c.dir_normal = (dir_normal != 0);
        c.p          = p;
        c.v          = v;
        c.t          = t;
        c.kp         = kp;
        c.kd         = kd;
        return c;
    endfunction

    // Spread over every magnitude so that any range setting sees values
    // inside, outside and right on its clamp points.
    function automatic logic signed [Q_W-1:0] random_q();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return $urandom;
        if (pick < 65)
            return $signed($urandom) >>> $urandom_range(31);
        if (pick < 85 && boundary_vals.size() > 0)
            return boundary_vals[$urandom_range(boundary_vals.size() - 1)];
        case ($urandom_range(3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            default: return 32'shFFFF_FFFF;
        endcase
    endfunction

    function automatic cmd_beat_t random_cmd();
        cmd_beat_t c;
        c.kind       = ($urandom_range(99) < 75) ? KIND_IMPEDANCE : kind_t'($urandom_range(3, 1));
        c.idx        = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(MOTORS - 1))
                                                 : IDX_W'($urandom_range(15, MOTORS));
        c.dir_normal = 1'($urandom_range(1));
        c.p          = random_q();
        c.v          = random_q();
        c.t          = random_q();
        c.kp         = random_q();
        c.kd         = random_q();
        return c;
    endfunction

    function automatic void note_boundaries(reg_set_t regs);
        logic signed [Q_W-1:0] pos, vel, stf, dmp, tlo, nar, wid;
        pos = {1'b0, regs[REG_POSITION_LIMIT][LIM_W-1:0]};
        vel = {1'b0, regs[REG_VELOCITY_LIMIT][LIM_W-1:0]};
        stf = {1'b0, regs[REG_STIFFNESS_MAX][LIM_W-1:0]};
        dmp = {1'b0, regs[REG_DAMPING_MAX][LIM_W-1:0]};
        tlo = regs[REG_TORQUE_MIN];
        nar = {1'b0, regs[REG_TORQUE_MAX_NARROW][LIM_W-1:0]};
        wid = {1'b0, regs[REG_TORQUE_MAX_WIDE][LIM_W-1:0]};
        boundary_vals = '{pos, -pos, pos + 1, -pos - 1, vel, -vel, vel + 1, -vel - 1,
                          stf, stf + 1, dmp, dmp + 1, tlo, tlo - 1, nar, nar + 1,
                          wid, wid + 1, 0, -1};
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is
    // taken. Valid stays high into the next beat unless an idle gap is drawn.
    task automatic offer_cmd(input cmd_beat_t c);
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd_bus.valid            <= 1'b1;
        cmd_bus.kind             <= c.kind;
        cmd_bus.motor_index      <= c.idx;
        cmd_bus.direction_normal <= c.dir_normal;
        cmd_bus.position_target  <= c.p;
        cmd_bus.velocity_target  <= c.v;
        cmd_bus.torque_target    <= c.t;
        cmd_bus.stiffness        <= c.kp;
        cmd_bus.damping          <= c.kd;
        do @(posedge clk); while (!cmd_bus.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Registers change only with the pipeline empty: every frame owed has
    // come out. This is also the sender's pause until the block runs dry.
    task automatic load_setting(input reg_set_t regs);
        while (frames_owed != 0)
            @(negedge clk);
        for (int r = 0; r < $size(regs); r++)
            write_reg(cfg_index_t'(r), regs[r]);
        note_boundaries(regs);
    endtask

    task automatic choose_setting(input int phase, output reg_set_t regs);
        case (phase)
            1: begin
                // widest ranges; bit 31 set on the unsigned bounds must be dropped
                regs[REG_POSITION_LIMIT]    = 32'hFFFF_FFFF;
                regs[REG_VELOCITY_LIMIT]    = 32'hFFFF_FFFF;
                regs[REG_STIFFNESS_MAX]     = 32'hFFFF_FFFF;
                regs[REG_DAMPING_MAX]       = 32'hFFFF_FFFF;
                regs[REG_TORQUE_MIN]        = 32'h8000_0000;
                regs[REG_TORQUE_MAX_NARROW] = 32'hFFFF_FFFF;
                regs[REG_TORQUE_MAX_WIDE]   = 32'h7FFF_FFFF;
                regs[REG_WIDE_TORQUE_MASK]  = 32'hFFFF_FFFF;
            end
            2: begin
                // narrowest legal ranges
                regs[REG_POSITION_LIMIT]    = 32'd1;
                regs[REG_VELOCITY_LIMIT]    = 32'd1;
                regs[REG_STIFFNESS_MAX]     = 32'd1;
                regs[REG_DAMPING_MAX]       = 32'd1;
                regs[REG_TORQUE_MIN]        = 32'd0;
                regs[REG_TORQUE_MAX_NARROW] = 32'd1;
                regs[REG_TORQUE_MAX_WIDE]   = 32'd1;
                regs[REG_WIDE_TORQUE_MASK]  = 32'd0;
            end
            3: begin
                // empty ranges everywhere, torque range inverted for both bounds
                regs[REG_POSITION_LIMIT]    = 32'd0;
                regs[REG_VELOCITY_LIMIT]    = 32'h8000_0000;
                regs[REG_STIFFNESS_MAX]     = 32'd0;
                regs[REG_DAMPING_MAX]       = 32'd0;
                regs[REG_TORQUE_MIN]        = 32'd5000;
                regs[REG_TORQUE_MAX_NARROW] = 32'd100;
                regs[REG_TORQUE_MAX_WIDE]   = 32'd0;
                regs[REG_WIDE_TORQUE_MASK]  = 32'h0000_02AA;
            end
            default: begin
                for (int r = 0; r < $size(regs); r++)
                    regs[r] = ($urandom_range(99) < 30) ? $urandom
                                                        : $urandom >> $urandom_range(31);
                // torque floor mostly at or below zero, sometimes above
                if ($urandom_range(99) < 80)
                    regs[REG_TORQUE_MIN] = -($urandom >> $urandom_range(31, 1));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Directed beats, run with the reset register values
    // ------------------------------------------------------------------------
    task automatic run_directed();
        // control kinds, with routing at both bus ends and past the last motor
        offer_cmd(make_cmd(KIND_ENABLE, 0, 1, 32'sh1234_5678, 0, 0, 0, 0));
        offer_cmd(make_cmd(KIND_DISABLE, 4, 0, 0, 32'shFFFF_FFFF, 0, 0, 0));
        offer_cmd(make_cmd(KIND_ZERO, 5, 1, 0, 0, 32'sh8000_0000, 0, 0));
        offer_cmd(make_cmd(KIND_ENABLE, 15, 1, 0, 0, 0, 32'sh7FFF_FFFF, 32'shFFFF_FFFF));
        offer_cmd(make_cmd(KIND_ZERO, 9, 0, 0, 0, 0, 0, 0));
        offer_cmd(make_cmd(KIND_DISABLE, 12, 1, 0, 0, 0, 0, 0));
        // all zero, both directions
        offer_cmd(make_cmd(KIND_IMPEDANCE, 0, 1, 0, 0, 0, 0, 0));
        offer_cmd(make_cmd(KIND_IMPEDANCE, 0, 0, 0, 0, 0, 0, 0));
        // every value right on its upper bound, narrow torque motor
        offer_cmd(make_cmd(KIND_IMPEDANCE, 9, 1, 819200, 2503475, 786432, 32768000, 327680));
        // lower bounds, wide torque motor at its wide limit
        offer_cmd(make_cmd(KIND_IMPEDANCE, 1, 1, -819200, -2503475, 1310720, 0, 0));
        // wide torque asked of a narrow motor: clamps to the narrow bound
        offer_cmd(make_cmd(KIND_IMPEDANCE, 0, 1, 0, 0, 1310720, 0, 0));
        // inverted direction on the most negative and most positive values
        offer_cmd(make_cmd(KIND_IMPEDANCE, 3, 0, 32'sh8000_0000, 32'sh8000_0000,
                           32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        offer_cmd(make_cmd(KIND_IMPEDANCE, 6, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        // negative gains clamp to zero
        offer_cmd(make_cmd(KIND_IMPEDANCE, 2, 0, 100000, -5000, -786432, -1, -1));
        // indices past the mask use the narrow bound
        offer_cmd(make_cmd(KIND_IMPEDANCE, 10, 1, 0, 0, 1310720, 0, 0));
        offer_cmd(make_cmd(KIND_IMPEDANCE, 15, 0, 32'sh0001_0000, 32'shFFFF_0000,
                           32'sh0000_8000, 32'sh0100_0000, 32'sh0002_0000));
        // one step outside each bound
        offer_cmd(make_cmd(KIND_IMPEDANCE, 8, 1, 819201, -2503476, -786433, 32768001, 327681));
        // smallest steps
        offer_cmd(make_cmd(KIND_IMPEDANCE, 7, 1, 1, -1, 1, 1, 1));
    endtask

    // ------------------------------------------------------------------------
    // Frame receiver: random stalls, plus one long hold-off on request so the
    // pipeline fills and the command side backs up
    // ------------------------------------------------------------------------
    initial
    begin : frame_receiver
        int hold_left;
        bit token_seen;
        hold_left       = 0;
        token_seen      = 1'b0;
        frame_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_token != token_seen) begin
                token_seen = hold_token;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                frame_bus.ready <= 1'b0;
            end else begin
                frame_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no beat moves on any channel for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (frame_bus.valid && frame_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("mit_command_frame_encoder test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        reg_set_t regs;

        rst_n                    = 1'b0;
        hold_token               = 1'b0;
        cmd_bus.valid            = 1'b0;
        cmd_bus.kind             = KIND_IMPEDANCE;
        cmd_bus.motor_index      = '0;
        cmd_bus.direction_normal = 1'b1;
        cmd_bus.position_target  = '0;
        cmd_bus.velocity_target  = '0;
        cmd_bus.torque_target    = '0;
        cmd_bus.stiffness        = '0;
        cmd_bus.damping          = '0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.index            = REG_POSITION_LIMIT;
        cfg_bus.data             = '0;

        // first idling mode: sender sparse gaps, receiver stalls heavily
        send_idle_pct  = 24;
        recv_stall_pct = 55;

        // boundaries of the reset values
        regs = '{32'd819200, 32'd2503475, 32'd32768000, 32'd327680, 32'hFFF4_0000,
                 32'd786432, 32'd1310720, 32'd462};
        note_boundaries(regs);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase 0 follows straight on, so valid is left to the next beat
        run_directed();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 3) begin
                send_idle_pct  = 55;
                recv_stall_pct = 24;
            end
            if (phase == 6) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // phase 0 keeps the reset values; the rest reprogram every register
            if (phase != 0) begin
                choose_setting(phase, regs);
                load_setting(regs);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 1 && n == HOLD_AT_ITEM)
                    hold_token <= ~hold_token;
                offer_cmd(random_cmd());
            end
            cmd_bus.valid <= 1'b0;
        end

        while (frames_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("mit_command_frame_encoder test passed");
        else
            $display("mit_command_frame_encoder test failed");
        $finish;
    end

endmodule
